// File: hw/rtl/clock_phase_delay_register_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clock phase delay register core
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PHASE_DELAY_REGISTER_CORE_ASSERT_SVH
`define CLOCK_PHASE_DELAY_REGISTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPDR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPDR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

// The expression must never be true.
`define CPDR_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error(msg);

`endif

// File: hw/rtl/cpdr_pkg.sv
// ----------------------------------------------------------------------------
// cpdr_pkg
// Widths, constants and control types shared by the phase delay register core.
// ----------------------------------------------------------------------------
`default_nettype none

package cpdr_pkg;

  // Field widths of the items and the configuration register.
  localparam int CMD_W   = 1;
  localparam int IDX_W   = 2;
  localparam int RATE_W  = 29;
  localparam int PHASE_W = 9;
  localparam int CTRL_W  = 12;
  localparam int DPS_W   = 7;
  localparam int COUNT_W = 8;

  // Default size of the register bank.
  localparam int NUM_PHASE_REGS_DEF = 4;

  // Saturation limit of the fine delay count.
  localparam int DELAY_COUNT_MAX = 255;

  // Reset value of the element delay in picoseconds.
  localparam logic [DPS_W-1:0] DPS_RESET = 7'd52;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_SET = 1'b0;
  localparam logic [CMD_W-1:0] CMD_GET = 1'b1;

  // Datapath of the serial arithmetic units.
  localparam int DW      = 54;
  localparam int MPW     = 9;
  localparam int QW      = 13;
  localparam int STEP_W  = 4;
  localparam int DEG_W   = 14;

  localparam logic [STEP_W-1:0] MUL_STEPS     = 4'd9;
  localparam logic [STEP_W-1:0] SET_DIV_STEPS = 4'd9;
  localparam logic [STEP_W-1:0] GET_DIV_STEPS = 4'd13;
  localparam int SET_DIV_SHIFT = 8;
  localparam int GET_DIV_SHIFT = 12;

  // Conditional subtractions of 360 shifted by 4 down to 0.
  localparam logic [2:0] MOD_TOP = 3'd4;

  // Arithmetic constants.
  localparam logic [DW-1:0] PS_PER_SECOND = 54'd1000000000000;
  localparam logic [DW-1:0] PS_HALF       = 54'd500000000000;
  localparam int FULL_TURN   = 360;
  localparam int QUARTER_DEG = 90;

  // Start and length of one run of a serial unit.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } unit_ctl_t;

  // Status of a serial unit; done pulses for one cycle with the result valid.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/cpdr_in_if.sv
// ----------------------------------------------------------------------------
// cpdr_in_if
// Request channel: valid/ready handshake with the command item payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpdr_in_if;
  logic                         valid;
  logic                         ready;
  logic [cpdr_pkg::CMD_W-1:0]   command;
  logic [cpdr_pkg::IDX_W-1:0]   register_index;
  logic [cpdr_pkg::RATE_W-1:0]  rate_hz;
  logic [cpdr_pkg::PHASE_W-1:0] phase_in_degrees;

  modport source (
    output valid, command, register_index, rate_hz, phase_in_degrees,
    input  ready
  );

  modport sink (
    input  valid, command, register_index, rate_hz, phase_in_degrees,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/cpdr_out_if.sv
// ----------------------------------------------------------------------------
// cpdr_out_if
// Response channel: valid/ready handshake with the result item payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpdr_out_if;
  logic                         valid;
  logic                         ready;
  logic [cpdr_pkg::PHASE_W-1:0] phase_out_degrees;
  logic [cpdr_pkg::CTRL_W-1:0]  control_value;
  logic                         rate_was_zero;

  modport source (
    output valid, phase_out_degrees, control_value, rate_was_zero,
    input  ready
  );

  modport sink (
    input  valid, phase_out_degrees, control_value, rate_was_zero,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/clock_phase_delay_register_core.sv
// ----------------------------------------------------------------------------
// clock_phase_delay_register_core
// Bank of clock phase control registers with set and get of a phase in degrees.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item: set stores a phase, get reads it back.
//   rsp returns exactly one result item per request item, in order.
//   cfg_wr_en with cfg_wr_data writes the element delay in picoseconds; write
//   it only while no item is in flight.
// Sequencing:
//   A zero rate or an index outside the bank goes straight to the finish
//   state, which loads the output register. Otherwise three 9-step shift-add
//   multiplications run on one serial multiplier, then a restoring divider
//   produces one quotient bit a cycle (9 bits for set, 13 for get), and a get
//   ends with 5 reduction steps modulo 360. One item is worked on at a time;
//   the next is accepted only after the result has entered the output
//   register.
// Reset and stall:
//   Reset clears all registers of the bank and sets the element delay to 52.
//   When rsp stalls, a finished result waits in the sequencer until the
//   output register is free; req stays not ready meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clock_phase_delay_register_core_assert.svh"

module clock_phase_delay_register_core #(
  parameter int NUM_PHASE_REGS = cpdr_pkg::NUM_PHASE_REGS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_wr_en,
  input  wire  [cpdr_pkg::DPS_W-1:0]   cfg_wr_data,
  cpdr_in_if.sink                      req,
  cpdr_out_if.source                   rsp
);

  localparam int AW = (NUM_PHASE_REGS > 1) ? $clog2(NUM_PHASE_REGS) : 1;
  localparam int XW = AW + cpdr_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_R,
    S_MUL_D,
    S_MUL_N,
    S_DIV,
    S_MOD,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration and register bank.
  logic [cpdr_pkg::DPS_W-1:0]  dps;
  logic [cpdr_pkg::CTRL_W-1:0] bank [NUM_PHASE_REGS];

  // Item context and intermediate results.
  logic [cpdr_pkg::CMD_W-1:0]   cmd_r;
  logic [AW-1:0]                addr_r;
  logic [1:0]                   quarter_r;
  logic [6:0]                   rem_r;
  logic [cpdr_pkg::CTRL_W-1:0]  reg_r;
  logic [cpdr_pkg::DW-1:0]      unit_r;
  logic                         unit_zero_r;
  logic [cpdr_pkg::DEG_W-1:0]   deg_r;
  logic [2:0]                   mod_k;
  logic [cpdr_pkg::PHASE_W-1:0] res_phase;
  logic [cpdr_pkg::CTRL_W-1:0]  res_ctrl;
  logic                         res_zero;
  logic                         wr_en_r;

  // Output register.
  logic                         out_valid_r;
  logic [cpdr_pkg::PHASE_W-1:0] out_phase_r;
  logic [cpdr_pkg::CTRL_W-1:0]  out_ctrl_r;
  logic                         out_zero_r;

  // Serial units.
  cpdr_pkg::unit_ctl_t          mul_ctl;
  cpdr_pkg::unit_sts_t          mul_sts;
  logic [cpdr_pkg::DW-1:0]      mul_mcand;
  logic [cpdr_pkg::MPW-1:0]     mul_mplier;
  logic [cpdr_pkg::DW-1:0]      mul_addend;
  logic [cpdr_pkg::DW-1:0]      mul_prod;
  cpdr_pkg::unit_ctl_t          div_ctl;
  cpdr_pkg::unit_sts_t          div_sts;
  logic [cpdr_pkg::DW-1:0]      div_num;
  logic [cpdr_pkg::DW-1:0]      div_den;
  logic [cpdr_pkg::QW-1:0]      div_quo;

  // Request decode.
  logic                         in_acc;
  logic [XW-1:0]                idx_ext;
  logic                         idx_ok;
  logic [AW-1:0]                idx_addr;
  logic [cpdr_pkg::CTRL_W-1:0]  rd_val;
  logic                         rate_zero;
  logic                         go;
  logic [2:0]                   q_full;
  logic [cpdr_pkg::PHASE_W-1:0] q_base;
  logic [6:0]                   rem_c;

  // Result shaping.
  logic [cpdr_pkg::COUNT_W-1:0] set_cnt;
  logic [cpdr_pkg::CTRL_W-1:0]  set_val;
  logic [cpdr_pkg::PHASE_W-1:0] q90;
  logic [cpdr_pkg::DEG_W-1:0]   deg_init;
  logic [cpdr_pkg::DEG_W-1:0]   mod_lim;
  logic [cpdr_pkg::DEG_W-1:0]   deg_step;
  logic                         finish_load;

  // Handshakes.
  assign req.ready   = (state == S_IDLE);
  assign in_acc      = req.valid && req.ready;
  assign finish_load = (state == S_FINISH) && (!out_valid_r || rsp.ready);

  assign rsp.valid             = out_valid_r;
  assign rsp.phase_out_degrees = out_phase_r;
  assign rsp.control_value     = out_ctrl_r;
  assign rsp.rate_was_zero     = out_zero_r;

  // Bank addressing: an index at or beyond the bank size reads as zero.
  assign idx_ext   = {AW'(0), req.register_index};
  assign idx_ok    = (idx_ext < XW'(NUM_PHASE_REGS));
  assign idx_addr  = idx_ext[AW-1:0];
  assign rd_val    = idx_ok ? bank[idx_addr] : '0;
  assign rate_zero = (req.rate_hz == '0);
  assign go        = !rate_zero && idx_ok;

  // Split the requested phase into a quarter count and a remainder.
  always_comb begin
    priority if (req.phase_in_degrees >= 9'd450) begin
      q_full = 3'd5;
    end else if (req.phase_in_degrees >= 9'd360) begin
      q_full = 3'd4;
    end else if (req.phase_in_degrees >= 9'd270) begin
      q_full = 3'd3;
    end else if (req.phase_in_degrees >= 9'd180) begin
      q_full = 3'd2;
    end else if (req.phase_in_degrees >= 9'd90) begin
      q_full = 3'd1;
    end else begin
      q_full = 3'd0;
    end
  end

  assign q_base = cpdr_pkg::PHASE_W'(q_full * cpdr_pkg::QUARTER_DEG);
  assign rem_c  = 7'(req.phase_in_degrees - q_base);

  // Set result: saturated count, enable when nonzero, quarter in bits 2:1.
  always_comb begin
    if (unit_zero_r) begin
      set_cnt = (rem_r != '0) ? cpdr_pkg::COUNT_W'(cpdr_pkg::DELAY_COUNT_MAX) : '0;
    end else if (div_quo > cpdr_pkg::QW'(cpdr_pkg::DELAY_COUNT_MAX)) begin
      set_cnt = cpdr_pkg::COUNT_W'(cpdr_pkg::DELAY_COUNT_MAX);
    end else begin
      set_cnt = div_quo[cpdr_pkg::COUNT_W-1:0];
    end
  end

  assign set_val = {(set_cnt != '0), set_cnt, quarter_r, 1'b0};

  // Get result: quarter degrees plus rounded fine degrees, then modulo 360.
  assign q90      = cpdr_pkg::PHASE_W'(reg_r[2:1] * cpdr_pkg::QUARTER_DEG);
  assign deg_init = cpdr_pkg::DEG_W'(q90) + cpdr_pkg::DEG_W'(div_quo);
  assign mod_lim  = cpdr_pkg::DEG_W'(cpdr_pkg::FULL_TURN) << mod_k;
  assign deg_step = (deg_r >= mod_lim) ? (deg_r - mod_lim) : deg_r;

  // Operand selection and start pulses for the serial units.
  always_comb begin
    mul_ctl       = '0;
    mul_ctl.steps = cpdr_pkg::MUL_STEPS;
    mul_mcand     = '0;
    mul_mplier    = '0;
    mul_addend    = '0;
    div_ctl       = '0;
    div_num       = mul_prod;
    div_den       = '0;
    unique case (state)
      S_IDLE: begin
        // Rate times 360.
        mul_ctl.start = in_acc && go;
        mul_mcand     = cpdr_pkg::DW'(req.rate_hz);
        mul_mplier    = cpdr_pkg::MPW'(cpdr_pkg::FULL_TURN);
      end
      S_MUL_R: begin
        // Times the element delay gives the conversion unit.
        mul_ctl.start = mul_sts.done;
        mul_mcand     = mul_prod;
        mul_mplier    = cpdr_pkg::MPW'(dps);
      end
      S_MUL_D: begin
        mul_ctl.start = mul_sts.done;
        if (cmd_r == cpdr_pkg::CMD_SET) begin
          // Picoseconds of the remainder plus half a unit for rounding.
          mul_mcand  = cpdr_pkg::PS_PER_SECOND;
          mul_mplier = cpdr_pkg::MPW'(rem_r);
          mul_addend = mul_prod >> 1;
        end else begin
          // Count times unit plus half a second for rounding.
          mul_mcand  = mul_prod;
          mul_mplier = reg_r[11] ? cpdr_pkg::MPW'(reg_r[10:3]) : '0;
          mul_addend = cpdr_pkg::PS_HALF;
        end
      end
      S_MUL_N: begin
        div_ctl.start = mul_sts.done;
        if (cmd_r == cpdr_pkg::CMD_SET) begin
          div_ctl.steps = cpdr_pkg::SET_DIV_STEPS;
          div_den       = unit_r << cpdr_pkg::SET_DIV_SHIFT;
        end else begin
          div_ctl.steps = cpdr_pkg::GET_DIV_STEPS;
          div_den       = cpdr_pkg::PS_PER_SECOND << cpdr_pkg::GET_DIV_SHIFT;
        end
      end
      default: begin
      end
    endcase
  end

  cpdr_shift_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mul_ctl),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .addend  (mul_addend),
    .sts     (mul_sts),
    .product (mul_prod)
  );

  cpdr_shift_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num (div_num),
    .den (div_den),
    .sts (div_sts),
    .quo (div_quo)
  );

  // Element delay configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dps <= cpdr_pkg::DPS_RESET;
    end else if (cfg_wr_en) begin
      dps <= cfg_wr_data;
    end
  end

  // Register bank, written when a set result moves to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PHASE_REGS; i++) begin
        bank[i] <= '0;
      end
    end else if (finish_load && wr_en_r) begin
      bank[addr_r] <= res_ctrl;
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_r <= 1'b0;
      wr_en_r     <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r     <= req.command;
            addr_r    <= idx_addr;
            quarter_r <= q_full[1:0];
            rem_r     <= rem_c;
            reg_r     <= rd_val;
            res_phase <= '0;
            res_ctrl  <= rd_val;
            res_zero  <= rate_zero;
            wr_en_r   <= 1'b0;
            state     <= go ? S_MUL_R : S_FINISH;
          end
        end
        S_MUL_R: begin
          if (mul_sts.done) begin
            state <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          if (mul_sts.done) begin
            unit_r      <= mul_prod;
            unit_zero_r <= (mul_prod == '0);
            state       <= S_MUL_N;
          end
        end
        S_MUL_N: begin
          if (mul_sts.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            if (cmd_r == cpdr_pkg::CMD_SET) begin
              res_ctrl <= set_val;
              wr_en_r  <= 1'b1;
              state    <= S_FINISH;
            end else begin
              deg_r <= deg_init;
              mod_k <= cpdr_pkg::MOD_TOP;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          deg_r <= deg_step;
          if (mod_k == '0) begin
            res_phase <= deg_step[cpdr_pkg::PHASE_W-1:0];
            state     <= S_FINISH;
          end else begin
            mod_k <= mod_k - 1'b1;
          end
        end
        S_FINISH: begin
          if (finish_load) begin
            out_valid_r <= 1'b1;
            out_phase_r <= res_phase;
            out_ctrl_r  <= res_ctrl;
            out_zero_r  <= res_zero;
            wr_en_r     <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item always occupies the sequencer in the next cycle.
  `CPDR_ASSERT_NXT(a_busy_after_accept, clk, rst, in_acc, state != S_IDLE,
                   "sequencer idle right after an accepted item")

  // The multiplier and the divider never run at the same time.
  `CPDR_ASSERT_NEVER(a_units_exclusive, clk, rst, mul_sts.busy && div_sts.busy,
                     "multiplier and divider busy together")

  // A stored delay count never exceeds the saturation limit.
  `CPDR_ASSERT_IMP(a_count_saturated, clk, rst, (state == S_FINISH) && wr_en_r,
                   res_ctrl[10:3] <= cpdr_pkg::COUNT_W'(cpdr_pkg::DELAY_COUNT_MAX),
                   "set result delay count above the limit")

  // The modulo reduction keeps the phase below 360 shifted by mod_k plus one.
  `CPDR_ASSERT_IMP(a_mod_bound, clk, rst, state == S_MOD,
                   {1'b0, deg_r} < (15'(cpdr_pkg::FULL_TURN) << (mod_k + 3'd1)),
                   "phase reduction out of range")

endmodule

`default_nettype wire

// File: hw/rtl/cpdr_shift_mul.sv
// ----------------------------------------------------------------------------
// cpdr_shift_mul
// Bit-serial shift-add multiplier with a preloaded addend, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdr_shift_mul (
  input  wire                             clk,
  input  wire                             rst,
  input  wire  cpdr_pkg::unit_ctl_t       ctl,
  input  wire  [cpdr_pkg::DW-1:0]         mcand,
  input  wire  [cpdr_pkg::MPW-1:0]        mplier,
  input  wire  [cpdr_pkg::DW-1:0]         addend,
  output cpdr_pkg::unit_sts_t             sts,
  output logic [cpdr_pkg::DW-1:0]         product
);

  logic [cpdr_pkg::DW-1:0]     mc;
  logic [cpdr_pkg::MPW-1:0]    mp;
  logic [cpdr_pkg::STEP_W-1:0] cnt;

  // Control: busy for the given number of steps, then a one-cycle done.
  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      cnt <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        sts.busy <= 1'b1;
        cnt      <= ctl.steps;
      end else if (sts.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == cpdr_pkg::STEP_W'(1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set multiplier bit.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      product <= addend;
      mc      <= mcand;
      mp      <= mplier;
    end else if (sts.busy) begin
      if (mp[0]) begin
        product <= product + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cpdr_shift_div.sv
// ----------------------------------------------------------------------------
// cpdr_shift_div
// Restoring divider, one quotient bit per cycle, divisor given pre-shifted.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdr_shift_div (
  input  wire                             clk,
  input  wire                             rst,
  input  wire  cpdr_pkg::unit_ctl_t       ctl,
  input  wire  [cpdr_pkg::DW-1:0]         num,
  input  wire  [cpdr_pkg::DW-1:0]         den,
  output cpdr_pkg::unit_sts_t             sts,
  output logic [cpdr_pkg::QW-1:0]         quo
);

  logic [cpdr_pkg::DW-1:0]     rem;
  logic [cpdr_pkg::DW-1:0]     dsh;
  logic [cpdr_pkg::STEP_W-1:0] cnt;
  logic                        ge;

  assign ge = (rem >= dsh);

  // Control: busy for the given number of quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
      cnt <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        sts.busy <= 1'b1;
        cnt      <= ctl.steps;
      end else if (sts.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == cpdr_pkg::STEP_W'(1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare, subtract, and shift in one quotient bit.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= num;
      dsh <= den;
      quo <= '0;
    end else if (sts.busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[cpdr_pkg::QW-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_clock_phase_delay_register_core.sv
// ----------------------------------------------------------------------------
// tb_clock_phase_delay_register_core
// Self-checking bench for the phase delay register bank. A short table of
// directed items covers reset contents, zero rate, saturation, wrapped phases
// and a zero element delay. Random set/get traffic follows over several
// element delay settings. Each accepted request is run through a local
// phase-to-delay predictor, and each response is compared field by field.
// ----------------------------------------------------------------------------

module tb_clock_phase_delay_register_core;

  localparam int NUM_REGS      = cpdr_pkg::NUM_PHASE_REGS_DEF;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int NUM_DIRECTED  = 25;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 155;
  localparam int DRAIN_CYCLES  = 60;
  localparam longint unsigned PS_PER_SEC  = 64'd1000000000000;
  localparam longint unsigned HALF_SEC_PS = 64'd500000000000;
  localparam logic [cpdr_pkg::RATE_W-1:0] RATE_MAX = '1;

  // One response item as the bank should produce it.
  typedef struct packed {
    logic [cpdr_pkg::PHASE_W-1:0] phase_out;
    logic [cpdr_pkg::CTRL_W-1:0]  ctrl;
    logic                         zero;
  } phase_result_t;

  // One row of the directed table, with an optional element delay write first.
  typedef struct packed {
    logic                         wr_cfg;
    logic [cpdr_pkg::DPS_W-1:0]   cfg;
    logic [cpdr_pkg::CMD_W-1:0]   cmd;
    logic [cpdr_pkg::IDX_W-1:0]   idx;
    logic [cpdr_pkg::RATE_W-1:0]  rate;
    logic [cpdr_pkg::PHASE_W-1:0] phase;
    logic                         typed;
    phase_result_t                res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [cpdr_pkg::DPS_W-1:0] cfg_wr_data;

  cpdr_in_if  req_if ();
  cpdr_out_if rsp_if ();

  clock_phase_delay_register_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  // Local copy of the bank and the element delay.
  logic [cpdr_pkg::CTRL_W-1:0] phase_regs_model [NUM_REGS];
  logic [cpdr_pkg::DPS_W-1:0]  elem_delay_ps;

  phase_result_t pending_results [$];
  int            mismatches  = 0;
  int            cycle_count = 0;
  int            stall_left  = 0;
  logic          idle_on     = 1'b1;

  localparam logic [cpdr_pkg::CMD_W-1:0] SET = cpdr_pkg::CMD_SET;
  localparam logic [cpdr_pkg::CMD_W-1:0] GET = cpdr_pkg::CMD_GET;

  // Directed items; the typed results are the ones that follow at a glance.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 7'd0,   GET, 2'd0, 29'd100000000, 9'd0,   1'b1, '{9'd0,   12'h000, 1'b0}},
    '{1'b0, 7'd0,   GET, 2'd3, 29'd0,         9'd0,   1'b1, '{9'd0,   12'h000, 1'b1}},
    '{1'b0, 7'd0,   SET, 2'd1, 29'd0,         9'd200, 1'b1, '{9'd0,   12'h000, 1'b1}},
    '{1'b0, 7'd0,   GET, 2'd1, 29'd1,         9'd0,   1'b1, '{9'd0,   12'h000, 1'b0}},
    '{1'b0, 7'd0,   SET, 2'd0, 29'd1,         9'd89,  1'b1, '{9'd0,   12'hFF8, 1'b0}},
    '{1'b0, 7'd0,   GET, 2'd0, 29'd1,         9'd0,   1'b1, '{9'd0,   12'hFF8, 1'b0}},
    '{1'b0, 7'd0,   SET, 2'd1, 29'd300000000, 9'd90,  1'b1, '{9'd0,   12'h002, 1'b0}},
    '{1'b0, 7'd0,   SET, 2'd2, 29'd300000000, 9'd270, 1'b1, '{9'd0,   12'h006, 1'b0}},
    '{1'b0, 7'd0,   GET, 2'd2, 29'd300000000, 9'd0,   1'b1, '{9'd270, 12'h006, 1'b0}},
    '{1'b0, 7'd0,   SET, 2'd3, 29'd123456789, 9'd360, 1'b1, '{9'd0,   12'h000, 1'b0}},
    '{1'b0, 7'd0,   SET, 2'd3, 29'd123456789, 9'd511, 1'b0, '0},
    '{1'b0, 7'd0,   GET, 2'd3, 29'd123456789, 9'd0,   1'b0, '0},
    '{1'b0, 7'd0,   SET, 2'd0, RATE_MAX,      9'd359, 1'b0, '0},
    '{1'b0, 7'd0,   GET, 2'd0, RATE_MAX,      9'd0,   1'b0, '0},
    '{1'b0, 7'd0,   SET, 2'd1, 29'd250000000, 9'd45,  1'b0, '0},
    '{1'b0, 7'd0,   GET, 2'd1, 29'd250000000, 9'd511, 1'b0, '0},
    '{1'b1, 7'd0,   SET, 2'd2, 29'd100000000, 9'd100, 1'b1, '{9'd0,   12'hFFA, 1'b0}},
    '{1'b0, 7'd0,   GET, 2'd2, 29'd100000000, 9'd0,   1'b1, '{9'd90,  12'hFFA, 1'b0}},
    '{1'b0, 7'd0,   SET, 2'd2, 29'd100000000, 9'd180, 1'b1, '{9'd0,   12'h004, 1'b0}},
    '{1'b1, 7'd127, SET, 2'd0, 29'd300000000, 9'd1,   1'b0, '0},
    '{1'b0, 7'd0,   GET, 2'd0, 29'd300000000, 9'd0,   1'b0, '0},
    '{1'b1, 7'd36,  SET, 2'd3, 29'd200000000, 9'd89,  1'b0, '0},
    '{1'b0, 7'd0,   GET, 2'd3, 29'd200000000, 9'd0,   1'b0, '0},
    '{1'b1, 7'd68,  SET, 2'd1, 29'd150000000, 9'd67,  1'b0, '0},
    '{1'b0, 7'd0,   GET, 2'd1, 29'd150000000, 9'd0,   1'b0, '0}
  };

  // Clock with a 20 unit period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Works out the response of one request and updates the local bank.
  function automatic phase_result_t predict_phase_step(
    input logic [cpdr_pkg::CMD_W-1:0]   cmd,
    input logic [cpdr_pkg::IDX_W-1:0]   idx,
    input logic [cpdr_pkg::RATE_W-1:0]  rate,
    input logic [cpdr_pkg::PHASE_W-1:0] phase
  );
    phase_result_t   res;
    longint unsigned unit_ps;
    longint unsigned rate64;
    longint unsigned dps64;
    longint unsigned rem;
    longint unsigned count;
    longint unsigned deg;
    int unsigned     quarter;
    logic [cpdr_pkg::CTRL_W-1:0] reg_val;
    rate64  = rate;
    dps64   = elem_delay_ps;
    unit_ps = dps64 * rate64 * 64'd360;
    reg_val = phase_regs_model[idx];
    res     = '0;
    res.zero = (rate == '0);
    if (!res.zero) begin
      if (cmd == cpdr_pkg::CMD_SET) begin
        quarter = phase / cpdr_pkg::QUARTER_DEG;
        rem     = phase % cpdr_pkg::QUARTER_DEG;
        // A zero element delay leaves only "none" or "all the elements".
        if (unit_ps == 0) begin
          count = (rem != 0) ? cpdr_pkg::DELAY_COUNT_MAX : 0;
        end else begin
          count = (PS_PER_SEC * rem + unit_ps / 2) / unit_ps;
        end
        if (count > cpdr_pkg::DELAY_COUNT_MAX) begin
          count = cpdr_pkg::DELAY_COUNT_MAX;
        end
        reg_val = {(count != 0), count[7:0], quarter[1:0], 1'b0};
        phase_regs_model[idx] = reg_val;
      end else begin
        deg = reg_val[2:1] * cpdr_pkg::QUARTER_DEG;
        if (reg_val[11]) begin
          deg += (reg_val[10:3] * unit_ps + HALF_SEC_PS) / PS_PER_SEC;
        end
        deg = deg % cpdr_pkg::FULL_TURN;
        res.phase_out = deg[cpdr_pkg::PHASE_W-1:0];
      end
    end
    res.ctrl = reg_val;
    return res;
  endfunction

  // Offers one request item, with an optional idle burst first.
  task automatic send_item(
    input logic [cpdr_pkg::CMD_W-1:0]   cmd,
    input logic [cpdr_pkg::IDX_W-1:0]   idx,
    input logic [cpdr_pkg::RATE_W-1:0]  rate,
    input logic [cpdr_pkg::PHASE_W-1:0] phase,
    input logic                         typed,
    input phase_result_t                typed_res
  );
    phase_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_if.valid            <= 1'b1;
    req_if.command          <= cmd;
    req_if.register_index   <= idx;
    req_if.rate_hz          <= rate;
    req_if.phase_in_degrees <= phase;
    do @(posedge clk); while (!req_if.ready);
    predicted = predict_phase_step(cmd, idx, rate, phase);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Waits until every response is back.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes the element delay once the bank is idle.
  task automatic write_elem_delay(input logic [cpdr_pkg::DPS_W-1:0] value);
    req_if.valid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    elem_delay_ps = value;
  endtask

  // Rate mix: off, very slow (saturating), full field range and typical.
  function automatic logic [cpdr_pkg::RATE_W-1:0] pick_rate();
    logic [cpdr_pkg::RATE_W-1:0] r;
    case ($urandom_range(0, 15))
      0:       r = '0;
      1, 2:    r = cpdr_pkg::RATE_W'($urandom_range(1, 2000));
      3:       r = cpdr_pkg::RATE_W'($urandom());
      4:       r = RATE_MAX;
      default: r = cpdr_pkg::RATE_W'($urandom_range(1, 300000000));
    endcase
    return r;
  endfunction

  // Phase mix: wrapped values, exact quarters, largest remainders and plain.
  function automatic logic [cpdr_pkg::PHASE_W-1:0] pick_phase();
    logic [cpdr_pkg::PHASE_W-1:0] p;
    case ($urandom_range(0, 7))
      0:       p = cpdr_pkg::PHASE_W'($urandom_range(360, 511));
      1:       p = cpdr_pkg::PHASE_W'(90 * $urandom_range(0, 3));
      2:       p = cpdr_pkg::PHASE_W'(90 * $urandom_range(0, 3) + 89);
      default: p = cpdr_pkg::PHASE_W'($urandom_range(0, 359));
    endcase
    return p;
  endfunction

  // Response side ready, with random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      rsp_if.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      rsp_if.ready  <= 1'b0;
    end else begin
      rsp_if.ready  <= 1'b1;
    end
  end

  // Compares each accepted response with the oldest expectation.
  always @(posedge clk) begin : check_results
    phase_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected response ctrl=%0h phase=%0d",
                                  rsp_if.control_value, rsp_if.phase_out_degrees));
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.phase_out_degrees !== want.phase_out) begin
          report_mismatch($sformatf("phase_out_degrees got %0d expected %0d",
                                    rsp_if.phase_out_degrees, want.phase_out));
        end
        if (rsp_if.control_value !== want.ctrl) begin
          report_mismatch($sformatf("control_value got %03h expected %03h",
                                    rsp_if.control_value, want.ctrl));
        end
        if (rsp_if.rate_was_zero !== want.zero) begin
          report_mismatch($sformatf("rate_was_zero got %0b expected %0b",
                                    rsp_if.rate_was_zero, want.zero));
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin : main_seq
    logic [cpdr_pkg::DPS_W-1:0]   phase_cfg [NUM_PHASES];
    logic [cpdr_pkg::CMD_W-1:0]   cmd;
    logic [cpdr_pkg::IDX_W-1:0]   idx;
    logic [cpdr_pkg::RATE_W-1:0]  rate;
    int                           sent;
    rst                     <= 1'b1;
    cfg_wr_en               <= 1'b0;
    cfg_wr_data             <= '0;
    req_if.valid            <= 1'b0;
    req_if.command          <= cpdr_pkg::CMD_SET;
    req_if.register_index   <= '0;
    req_if.rate_hz          <= '0;
    req_if.phase_in_degrees <= '0;
    elem_delay_ps = cpdr_pkg::DPS_RESET;
    foreach (phase_regs_model[i]) phase_regs_model[i] = '0;
    phase_cfg = '{7'd52, 7'd36, 7'd68, 7'd0, 7'd127, 7'd0, 7'd0, 7'd0, 7'd52, 7'd0};
    phase_cfg[5] = cpdr_pkg::DPS_W'($urandom_range(36, 68));
    phase_cfg[6] = cpdr_pkg::DPS_W'($urandom_range(0, 127));
    phase_cfg[7] = cpdr_pkg::DPS_W'($urandom_range(36, 68));
    phase_cfg[9] = cpdr_pkg::DPS_W'($urandom_range(36, 68));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr_cfg) begin
        write_elem_delay(directed_rows[i].cfg);
      end
      send_item(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].rate,
                directed_rows[i].phase, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases, one element delay setting each; the last runs without idling.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_elem_delay(phase_cfg[ph]);
      if (ph == NUM_PHASES - 1) begin
        idle_on = 1'b0;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        idx  = cpdr_pkg::IDX_W'($urandom_range(0, NUM_REGS - 1));
        rate = pick_rate();
        if ($urandom_range(0, 2) == 0) begin
          // Round trip: store a phase, then read it back at the same rate.
          send_item(cpdr_pkg::CMD_SET, idx, rate, pick_phase(), 1'b0, '0);
          send_item(cpdr_pkg::CMD_GET, idx, rate, 9'($urandom()), 1'b0, '0);
          sent += 2;
        end else begin
          cmd = cpdr_pkg::CMD_W'($urandom_range(0, 1));
          send_item(cmd, idx, rate, pick_phase(), 1'b0, '0);
          sent++;
        end
      end
    end

    req_if.valid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: clock_phase_delay_register_core.f
+incdir+hw/rtl
hw/rtl/cpdr_pkg.sv
hw/rtl/cpdr_in_if.sv
hw/rtl/cpdr_out_if.sv
hw/rtl/cpdr_shift_mul.sv
hw/rtl/cpdr_shift_div.sv
hw/rtl/clock_phase_delay_register_core.sv
tb/tb_clock_phase_delay_register_core.sv
